// ===== rtl/core/pps_pkg.sv =====
// Shared types and codes of the periodic poll scheduler.
package pps_pkg;

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_ADD     = 3'd1;
   localparam logic [2:0] MODE_UPDATE  = 3'd2;
   localparam logic [2:0] MODE_REMOVE  = 3'd3;
   localparam logic [2:0] MODE_ERROR   = 3'd4;
   localparam logic [2:0] MODE_SUCCESS = 3'd5;

   localparam logic [1:0] KIND_CMD    = 2'd0;
   localparam logic [1:0] KIND_DROP   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_DUP       = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   localparam logic [6:0] ERR_CAP       = 7'd100;
   localparam logic [6:0] BACKOFF_START = 7'd3;
   localparam logic [6:0] BACKOFF_FULL  = 7'd5;
   localparam logic [5:0] SKIP_MAX      = 6'd32;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] interval;
      logic [1:0]  bus;
      logic [15:0] tmpl;
      logic        has_tmpl;
      logic        enabled;
      logic [31:0] last_time;
      logic [6:0]  errors;
      logic [5:0]  skips;
   } slot_entry_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_WALK,
      CTL_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic walk;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic mode_known;
      logic walk_done;
      logic fin_done;
   } dp_status_type;

endpackage

// ===== rtl/core/pps_if.sv =====
// Item channels of the poll scheduler: request and response.
interface pps_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [31:0] chan_id;
   logic [31:0] interval_ticks;
   logic [1:0]  bus_kind;
   logic [15:0] template_ref;
   logic        has_template;
   logic        chan_enabled;
   logic [31:0] now_ticks;
   logic        backpressure;

   modport source (output valid, mode, chan_id, interval_ticks, bus_kind, template_ref,
                   has_template, chan_enabled, now_ticks, backpressure, input ready);
   modport sink (input valid, mode, chan_id, interval_ticks, bus_kind, template_ref,
                 has_template, chan_enabled, now_ticks, backpressure, output ready);
endinterface

interface pps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  status;
   logic [31:0] out_chan_id;
   logic [1:0]  out_bus_kind;
   logic [15:0] out_template;
   logic [3:0]  active_count;
   logic        last;

   modport source (output valid, kind, status, out_chan_id, out_bus_kind, out_template,
                   active_count, last, input ready);
   modport sink (input valid, kind, status, out_chan_id, out_bus_kind, out_template,
                 active_count, last, output ready);
endinterface

// ===== rtl/core/pps_ctrl.sv =====
// Sequencing state machine of the poll scheduler: accept, slot walk, final result.
module pps_ctrl
   import pps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctl_cmd_type   cmd,
   output ctl_state_type state
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // Unused modes are taken and dropped without any result.
               if (sts.mode_known) begin
                  state_in = CTL_WALK;
               end
            end
         end
         CTL_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done) begin
               state_in = CTL_FINISH;
            end
         end
         CTL_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.fin_done) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ===== rtl/core/pps_datapath.sv =====
// Slot table, slot walk pipeline, table updates and result register of the poll scheduler.
module pps_datapath
   import pps_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ctl_cmd_type                       cmd,
   output dp_status_type                     sts,
   output logic [$clog2(CHANNELS + 1) - 1:0] act_cnt,
   input  logic [2:0]                        req_mode,
   input  logic [31:0]                       req_chan_id,
   input  logic [31:0]                       req_interval_ticks,
   input  logic [1:0]                        req_bus_kind,
   input  logic [15:0]                       req_template_ref,
   input  logic                              req_has_template,
   input  logic                              req_chan_enabled,
   input  logic [31:0]                       req_now_ticks,
   input  logic                              req_backpressure,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_kind,
   output logic [1:0]                        rsp_status,
   output logic [31:0]                       rsp_out_chan_id,
   output logic [1:0]                        rsp_out_bus_kind,
   output logic [15:0]                       rsp_out_template,
   output logic [3:0]                        rsp_active_count,
   output logic                              rsp_last
);

   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CW = $clog2(CHANNELS + 1);
   localparam logic [IW:0] END_IDX = (IW + 1)'(CHANNELS);

   // Latched request item.
   logic [2:0]  mode_ff;
   logic [31:0] id_ff;
   logic [31:0] intv_ff;
   logic [1:0]  bus_ff;
   logic [15:0] tmpl_ff;
   logic        has_ff;
   logic        en_ff;
   logic [31:0] now_ff;
   logic        press_ff;

   // Slot table: payload in a memory, active bits in flops.
   slot_entry_type slot_mem_ff [CHANNELS];
   logic [CHANNELS-1:0] act_ff, act_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   // Walk pipeline: read address, then evaluation of the read entry.
   logic [IW:0]    rd_idx_ff;
   logic           ev_vld_ff;
   logic [IW-1:0]  ev_idx_ff;
   slot_entry_type ev_ff;

   // Search results of a table walk.
   logic           found_ff;
   logic [IW-1:0]  m_idx_ff;
   slot_entry_type m_ff;
   logic           free_ff;
   logic [IW-1:0]  free_idx_ff;

   // Result register.
   logic        out_vld_ff;
   logic [1:0]  out_kind_ff;
   logic [1:0]  out_status_ff;
   logic [31:0] out_id_ff;
   logic [1:0]  out_bus_ff;
   logic [15:0] out_tmpl_ff;
   logic [3:0]  out_cnt_ff;
   logic        out_last_ff;

   logic           tick;
   logic           out_free;
   logic           ev_act;
   logic [31:0]    elapsed;
   logic           due;
   logic           backoff;
   logic [5:0]     thr;
   logic [5:0]     skips_inc;
   logic           proceed;
   slot_entry_type wb_entry;
   logic           emit_need;
   logic           advance;
   logic           is_match;
   logic           rd_en;
   logic           wr_en;
   logic [IW-1:0]  wr_idx;
   slot_entry_type wr_data;
   logic           fin_load;
   logic           fin_wr;
   logic [IW-1:0]  fin_idx;
   slot_entry_type fin_data;
   logic [1:0]     fin_status;
   logic [CW+3:0]  cnt_ext;
   logic [CW+3:0]  cnt_next_ext;

   assign tick     = (mode_ff == MODE_TICK);
   assign out_free = !out_vld_ff || rsp_ready;
   assign ev_act   = act_ff[ev_idx_ff];

   // Due test and exponential backoff for the slot under evaluation.
   always_comb begin
      elapsed   = now_ff - ev_ff.last_time;
      due       = ev_act && ev_ff.enabled && (elapsed >= ev_ff.interval);
      backoff   = ev_ff.errors > BACKOFF_START;
      thr       = (ev_ff.errors > BACKOFF_FULL) ? SKIP_MAX
                : (6'd1 << (ev_ff.errors[2:0] - BACKOFF_START[2:0]));
      skips_inc = ev_ff.skips + 6'd1;
      proceed   = !backoff || (skips_inc >= thr);
      wb_entry  = ev_ff;
      if (backoff) begin
         wb_entry.skips = proceed ? 6'd0 : skips_inc;
      end
      if (proceed) begin
         wb_entry.last_time = now_ff;
      end
   end

   assign emit_need = ev_vld_ff && tick && due && proceed && (press_ff || ev_ff.has_tmpl);
   assign advance   = cmd.walk && !(emit_need && !out_free);
   assign is_match  = ev_act && (ev_ff.id == id_ff);
   assign rd_en     = advance && (rd_idx_ff != END_IDX);

   // Final result and table change of the item.
   always_comb begin
      fin_status = STS_OK;
      fin_wr     = 1'b0;
      fin_idx    = m_idx_ff;
      fin_data   = m_ff;
      act_in     = act_ff;
      cnt_in     = cnt_ff;
      case (mode_ff)
         MODE_TICK: begin
            fin_status = STS_OK;
         end
         MODE_ADD: begin
            if (found_ff) begin
               fin_status = STS_DUP;
            end else if (!free_ff) begin
               fin_status = STS_FULL;
            end else begin
               fin_wr             = 1'b1;
               fin_idx            = free_idx_ff;
               fin_data.id        = id_ff;
               fin_data.interval  = intv_ff;
               fin_data.bus       = bus_ff;
               fin_data.tmpl      = tmpl_ff;
               fin_data.has_tmpl  = has_ff;
               fin_data.enabled   = en_ff;
               fin_data.last_time = '0;
               fin_data.errors    = '0;
               fin_data.skips     = '0;
               act_in[free_idx_ff] = 1'b1;
               cnt_in             = cnt_ff + CW'(1);
            end
         end
         default: begin
            if (!found_ff) begin
               fin_status = STS_NOT_FOUND;
            end else begin
               case (mode_ff)
                  MODE_UPDATE: begin
                     fin_wr            = 1'b1;
                     fin_data.interval = intv_ff;
                     fin_data.bus      = bus_ff;
                     fin_data.tmpl     = tmpl_ff;
                     fin_data.has_tmpl = has_ff;
                     fin_data.enabled  = en_ff;
                  end
                  MODE_REMOVE: begin
                     act_in[m_idx_ff] = 1'b0;
                     cnt_in           = cnt_ff - CW'(1);
                  end
                  MODE_ERROR: begin
                     fin_wr          = 1'b1;
                     fin_data.errors = (m_ff.errors < ERR_CAP) ? m_ff.errors + 7'd1 : ERR_CAP;
                  end
                  default: begin
                     fin_wr          = 1'b1;
                     fin_data.errors = (m_ff.errors != 7'd0) ? m_ff.errors - 7'd1 : 7'd0;
                     fin_data.skips  = '0;
                  end
               endcase
            end
         end
      endcase
   end

   assign fin_load     = cmd.finish && out_free;
   assign cnt_ext      = {4'b0, cnt_ff};
   assign cnt_next_ext = {4'b0, cnt_in};

   // Walk write-back and final update share the single write port.
   always_comb begin
      if (cmd.walk) begin
         wr_en   = advance && ev_vld_ff && tick && due;
         wr_idx  = ev_idx_ff;
         wr_data = wb_entry;
      end else begin
         wr_en   = fin_load && fin_wr;
         wr_idx  = fin_idx;
         wr_data = fin_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         ev_ff <= slot_mem_ff[rd_idx_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         id_ff    <= req_chan_id;
         intv_ff  <= req_interval_ticks;
         bus_ff   <= req_bus_kind;
         tmpl_ff  <= req_template_ref;
         has_ff   <= req_has_template;
         en_ff    <= req_chan_enabled;
         now_ff   <= req_now_ticks;
         press_ff <= req_backpressure;
      end
      if (rd_en) begin
         ev_idx_ff <= rd_idx_ff[IW-1:0];
      end
      if (advance && ev_vld_ff && !tick) begin
         if (is_match && !found_ff) begin
            m_idx_ff <= ev_idx_ff;
            m_ff     <= ev_ff;
         end
         if (!ev_act && !free_ff) begin
            free_idx_ff <= ev_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= '0;
         cnt_ff    <= '0;
         rd_idx_ff <= '0;
         ev_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         free_ff   <= 1'b0;
      end else begin
         if (fin_load) begin
            act_ff <= act_in;
            cnt_ff <= cnt_in;
         end
         if (cmd.load) begin
            rd_idx_ff <= '0;
            ev_vld_ff <= 1'b0;
            found_ff  <= 1'b0;
            free_ff   <= 1'b0;
         end else if (advance) begin
            ev_vld_ff <= rd_en;
            if (rd_en) begin
               rd_idx_ff <= rd_idx_ff + (IW + 1)'(1);
            end
            if (ev_vld_ff && !tick) begin
               if (is_match) begin
                  found_ff <= 1'b1;
               end
               if (!ev_act) begin
                  free_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if ((advance && emit_need) || fin_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit_need) begin
         out_kind_ff   <= press_ff ? KIND_DROP : KIND_CMD;
         out_status_ff <= STS_OK;
         out_id_ff     <= ev_ff.id;
         out_bus_ff    <= ev_ff.bus;
         out_tmpl_ff   <= ev_ff.tmpl;
         out_cnt_ff    <= cnt_ext[3:0];
         out_last_ff   <= 1'b0;
      end else if (fin_load) begin
         out_kind_ff   <= tick ? KIND_DONE : KIND_STATUS;
         out_status_ff <= fin_status;
         out_id_ff     <= '0;
         out_bus_ff    <= '0;
         out_tmpl_ff   <= '0;
         out_cnt_ff    <= cnt_next_ext[3:0];
         out_last_ff   <= 1'b1;
      end
   end

   assign sts.mode_known = (req_mode <= MODE_SUCCESS);
   assign sts.walk_done  = cmd.walk && (rd_idx_ff == END_IDX) && !ev_vld_ff;
   assign sts.fin_done   = fin_load;
   assign act_cnt        = cnt_ff;

   assign rsp_valid        = out_vld_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_out_chan_id  = out_id_ff;
   assign rsp_out_bus_kind = out_bus_ff;
   assign rsp_out_template = out_tmpl_ff;
   assign rsp_active_count = out_cnt_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ===== rtl/core/periodic_poll_scheduler_backoff.sv =====
// Top level of the periodic poll scheduler with exponential backoff.
//
//   channel | direction | handshake     | carries
//   req     | in        | valid / ready | mode, channel config, tick time, queue pressure
//   rsp     | out       | valid / ready | sample commands, drops, status, tick done
//
// An item is taken, then walked slot by slot through the table memory (one slot read per
// cycle while the walk is not held, the evaluation registered behind the read, and a
// closing step), and then given its final result.
// Unused modes are dropped without a walk. Reset is synchronous; it clears the active bits, so no
// table clearing pass follows it. A stalled rsp holds the walk at the slot whose sample
// waits for the result register; a new item is taken once the final result is loaded.
module periodic_poll_scheduler_backoff
   import pps_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input logic       clock,
   input logic       reset,
   pps_req_if.sink   req,
   pps_rsp_if.source rsp
);

   ctl_cmd_type   cmd;
   dp_status_type sts;
   ctl_state_type state;
   logic [$clog2(CHANNELS + 1) - 1:0] act_cnt;

   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   pps_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .act_cnt            (act_cnt),
      .req_mode           (req.mode),
      .req_chan_id        (req.chan_id),
      .req_interval_ticks (req.interval_ticks),
      .req_bus_kind       (req.bus_kind),
      .req_template_ref   (req.template_ref),
      .req_has_template   (req.has_template),
      .req_chan_enabled   (req.chan_enabled),
      .req_now_ticks      (req.now_ticks),
      .req_backpressure   (req.backpressure),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_kind           (rsp.kind),
      .rsp_status         (rsp.status),
      .rsp_out_chan_id    (rsp.out_chan_id),
      .rsp_out_bus_kind   (rsp.out_bus_kind),
      .rsp_out_template   (rsp.out_template),
      .rsp_active_count   (rsp.active_count),
      .rsp_last           (rsp.last)
   );

   // A table operation gives exactly one item, so a status result is always the last.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.kind == KIND_STATUS) |-> rsp.last)
      else $error("status result without last");

   // Samples are never the final result of a tick.
   a_sample_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && ((rsp.kind == KIND_CMD) || (rsp.kind == KIND_DROP)) |-> !rsp.last)
      else $error("sample result marked last");

   // The active count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      act_cnt <= ($clog2(CHANNELS + 1))'(CHANNELS))
      else $error("active count above table size");

   // A known mode starts a walk, so the next cycle takes no item.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && (req.mode <= MODE_SUCCESS) |=> !req.ready && (state == CTL_WALK))
      else $error("item taken without walk");

endmodule

// ===== tb/sv/poll_sched_checker.sv =====
`timescale 1ns / 1ps
// Checker for the poll scheduler: keeps its own channel table, predicts results and compares them.
module poll_sched_checker
   import pps_pkg::*;
#(
   parameter int CHANNELS = 8
) (
   input  logic clock,
   input  logic reset,
   pps_req_if   req,
   pps_rsp_if   rsp,
   output int   fail_count,
   output int   pending,
   output int   results_checked,
   output int   issued_count,
   output int   drop_count,
   output int   backoff_holds
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [31:0] chan_id;
      logic [1:0]  bus;
      logic [15:0] tmpl;
      logic [3:0]  active_count;
      logic        last;
   } poll_result_type;

   slot_entry_type  slot_store [CHANNELS];
   logic            slot_live [CHANNELS];
   poll_result_type expected_results [$];

   int failures = 0;
   int checked = 0;
   int cmds = 0;
   int drops = 0;
   int holds = 0;

   function automatic logic [3:0] live_count();
      int c;
      c = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (slot_live[i]) c++;
      end
      return 4'(c);
   endfunction

   function automatic int find_channel(input logic [31:0] id);
      for (int i = 0; i < CHANNELS; i++) begin
         if (slot_live[i] && slot_store[i].id == id) return i;
      end
      return -1;
   endfunction

   // Slot index -1 gives a result without channel fields.
   task automatic push_result(input logic [1:0] kind, input logic [1:0] status, input int s,
                              input logic last);
      poll_result_type r;
      r = '0;
      r.kind = kind;
      r.status = status;
      if (s >= 0) begin
         r.chan_id = slot_store[s].id;
         r.bus = slot_store[s].bus;
         r.tmpl = slot_store[s].tmpl;
      end
      r.active_count = live_count();
      r.last = last;
      expected_results.push_back(r);
   endtask

   task automatic predict_results(input logic [2:0] mode, input logic [31:0] id,
                                  input logic [31:0] interval, input logic [1:0] bus,
                                  input logic [15:0] tmpl, input logic has_tmpl,
                                  input logic enabled, input logic [31:0] now,
                                  input logic pressure);
      int s;
      int f;
      logic [6:0] hold_limit;
      s = find_channel(id);
      case (mode)
         MODE_TICK: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (!slot_live[i] || !slot_store[i].enabled) continue;
               // The elapsed time is taken modulo 2^32.
               if (now - slot_store[i].last_time < slot_store[i].interval) continue;
               if (slot_store[i].errors > BACKOFF_START) begin
                  hold_limit = (slot_store[i].errors > BACKOFF_FULL) ? 7'(SKIP_MAX) :
                               7'd1 << (slot_store[i].errors - BACKOFF_START);
                  slot_store[i].skips = slot_store[i].skips + 6'd1;
                  if (slot_store[i].skips < hold_limit) begin
                     holds++;
                     continue;
                  end
                  slot_store[i].skips = '0;
               end
               slot_store[i].last_time = now;
               if (pressure) begin
                  push_result(KIND_DROP, STS_OK, i, 1'b0);
                  drops++;
               end else if (slot_store[i].has_tmpl) begin
                  push_result(KIND_CMD, STS_OK, i, 1'b0);
                  cmds++;
               end
            end
            push_result(KIND_DONE, STS_OK, -1, 1'b1);
         end
         MODE_ADD: begin
            if (s >= 0) begin
               push_result(KIND_STATUS, STS_DUP, -1, 1'b1);
            end else begin
               f = -1;
               for (int i = CHANNELS - 1; i >= 0; i--) begin
                  if (!slot_live[i]) f = i;
               end
               if (f < 0) begin
                  push_result(KIND_STATUS, STS_FULL, -1, 1'b1);
               end else begin
                  slot_store[f] = '{id: id, interval: interval, bus: bus, tmpl: tmpl,
                                    has_tmpl: has_tmpl, enabled: enabled, last_time: '0,
                                    errors: '0, skips: '0};
                  slot_live[f] = 1'b1;
                  push_result(KIND_STATUS, STS_OK, -1, 1'b1);
               end
            end
         end
         MODE_UPDATE, MODE_REMOVE, MODE_ERROR, MODE_SUCCESS: begin
            if (s < 0) begin
               push_result(KIND_STATUS, STS_NOT_FOUND, -1, 1'b1);
            end else begin
               case (mode)
                  MODE_UPDATE: begin
                     slot_store[s].interval = interval;
                     slot_store[s].bus = bus;
                     slot_store[s].tmpl = tmpl;
                     slot_store[s].has_tmpl = has_tmpl;
                     slot_store[s].enabled = enabled;
                  end
                  MODE_REMOVE: slot_live[s] = 1'b0;
                  MODE_ERROR: begin
                     if (slot_store[s].errors < ERR_CAP) begin
                        slot_store[s].errors = slot_store[s].errors + 7'd1;
                     end
                  end
                  default: begin
                     if (slot_store[s].errors != '0) begin
                        slot_store[s].errors = slot_store[s].errors - 7'd1;
                     end
                     slot_store[s].skips = '0;
                  end
               endcase
               push_result(KIND_STATUS, STS_OK, -1, 1'b1);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("Field %s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      poll_result_type want;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            slot_live[i] = 1'b0;
            slot_store[i] = '0;
         end
         expected_results.delete();
      end else begin
         // Results are compared before the new item is predicted, so that a stray
         // result can never be matched with an expectation of the same edge.
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               $error("Unexpected result: kind %0d, chan_id 0x%0h", rsp.kind, rsp.out_chan_id);
               failures++;
            end else begin
               want = expected_results.pop_front();
               compare_field("kind", want.kind, rsp.kind);
               compare_field("status", want.status, rsp.status);
               compare_field("out_chan_id", want.chan_id, rsp.out_chan_id);
               compare_field("out_bus_kind", want.bus, rsp.out_bus_kind);
               compare_field("out_template", want.tmpl, rsp.out_template);
               compare_field("active_count", want.active_count, rsp.active_count);
               compare_field("last", want.last, rsp.last);
               checked++;
            end
         end
         if (req.valid && req.ready) begin
            predict_results(req.mode, req.chan_id, req.interval_ticks, req.bus_kind,
                            req.template_ref, req.has_template, req.chan_enabled,
                            req.now_ticks, req.backpressure);
         end
      end
      fail_count <= failures;
      pending <= expected_results.size();
      results_checked <= checked;
      issued_count <= cmds;
      drop_count <= drops;
      backoff_holds <= holds;
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top of the poll scheduler: clock, reset, stimulus and the final verdict.
module testbench
   import pps_pkg::*;
();

   localparam int CHANNELS    = 8;
   localparam int TOTAL_ITEMS = 370;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int POOL_SIZE   = 12;
   localparam int ERROR_BURST = 102;

   // Modes that the block ignores.
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] chan_id;
      logic [31:0] interval_ticks;
      logic [1:0]  bus_kind;
      logic [15:0] template_ref;
      logic        has_template;
      logic        chan_enabled;
      logic [31:0] now_ticks;
      logic        backpressure;
   } poll_req_type;

   logic clock;
   logic reset;

   pps_req_if req_ch ();
   pps_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int results_checked;
   int issued_count;
   int drop_count;
   int backoff_holds;

   int cycle_count = 0;
   int items_sent = 0;
   int ticks_sent = 0;
   int stall_left = 0;
   bit steady = 1'b0;
   logic [31:0] id_pool [POOL_SIZE];
   logic [31:0] tick_now;

   periodic_poll_scheduler_backoff #(
      .CHANNELS(CHANNELS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   poll_sched_checker #(
      .CHANNELS(CHANNELS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .fail_count     (fail_count),
      .pending        (pending),
      .results_checked(results_checked),
      .issued_count   (issued_count),
      .drop_count     (drop_count),
      .backoff_holds  (backoff_holds)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Mostly short idle spans, a few long ones; none while the steady flag is set.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 30) begin
         stall_left <= idle_span();
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Valid is only lowered when a gap follows, so it is never lowered and raised in one step.
   task automatic send_item(input poll_req_type it);
      int gap;
      gap = idle_span();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= it.mode;
      req_ch.chan_id <= it.chan_id;
      req_ch.interval_ticks <= it.interval_ticks;
      req_ch.bus_kind <= it.bus_kind;
      req_ch.template_ref <= it.template_ref;
      req_ch.has_template <= it.has_template;
      req_ch.chan_enabled <= it.chan_enabled;
      req_ch.now_ticks <= it.now_ticks;
      req_ch.backpressure <= it.backpressure;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (it.mode <= MODE_SUCCESS) items_sent++;
      if (it.mode == MODE_TICK) ticks_sent++;
   endtask

   function automatic poll_req_type noise_item();
      poll_req_type it;
      it.mode = 3'($urandom_range(0, 7));
      it.chan_id = $urandom;
      it.interval_ticks = $urandom;
      it.bus_kind = 2'($urandom_range(0, 3));
      it.template_ref = 16'($urandom_range(0, 16'hFFFF));
      it.has_template = 1'($urandom_range(0, 1));
      it.chan_enabled = 1'($urandom_range(0, 1));
      it.now_ticks = $urandom;
      it.backpressure = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic poll_req_type make_item(input logic [2:0] mode, input logic [31:0] id);
      poll_req_type it;
      it = noise_item();
      it.mode = mode;
      it.chan_id = id;
      return it;
   endfunction

   function automatic poll_req_type config_item(input logic [2:0] mode, input logic [31:0] id,
                                                input logic [31:0] interval,
                                                input logic [1:0] bus, input logic [15:0] tmpl,
                                                input logic has_tmpl, input logic enabled);
      poll_req_type it;
      it = make_item(mode, id);
      it.interval_ticks = interval;
      it.bus_kind = bus;
      it.template_ref = tmpl;
      it.has_template = has_tmpl;
      it.chan_enabled = enabled;
      return it;
   endfunction

   function automatic poll_req_type tick_item(input logic [31:0] now, input logic pressure);
      poll_req_type it;
      it = make_item(MODE_TICK, $urandom);
      it.now_ticks = now;
      it.backpressure = pressure;
      return it;
   endfunction

   function automatic logic [31:0] pick_interval();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'd0;
      if (r < 75) return $urandom_range(1, 40);
      if (r < 85) return $urandom_range(41, 1000);
      if (r < 95) return $urandom;
      return 32'hFFFF_FFFF;
   endfunction

   initial begin
      poll_req_type it;
      int pick;
      int burst_at;
      int round;
      logic [31:0] burst_id;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_TICK;
      req_ch.chan_id = '0;
      req_ch.interval_ticks = '0;
      req_ch.bus_kind = '0;
      req_ch.template_ref = '0;
      req_ch.has_template = 1'b0;
      req_ch.chan_enabled = 1'b0;
      req_ch.now_ticks = '0;
      req_ch.backpressure = 1'b0;
      foreach (id_pool[i]) id_pool[i] = $urandom;
      id_pool[0] = 32'd0;
      id_pool[1] = 32'hFFFF_FFFF;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, misses, full table, extreme fields, pressure, wrap.
      send_item(tick_item(32'd0, 1'b0));
      send_item(make_item(MODE_UPDATE, 32'd9));
      send_item(make_item(MODE_REMOVE, 32'd9));
      send_item(make_item(MODE_ERROR, 32'd9));
      send_item(make_item(MODE_SUCCESS, 32'd9));
      send_item(config_item(MODE_ADD, 32'd0, 32'd0, 2'd0, 16'h0000, 1'b1, 1'b1));
      send_item(config_item(MODE_ADD, 32'd0, 32'd7, 2'd1, 16'h0001, 1'b1, 1'b1));
      send_item(config_item(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 16'hFFFF,
                            1'b1, 1'b1));
      send_item(config_item(MODE_ADD, 32'd1, 32'd2, 2'd1, 16'h1234, 1'b1, 1'b1));
      send_item(config_item(MODE_ADD, 32'd2, 32'd5, 2'd2, 16'hABCD, 1'b0, 1'b1));
      send_item(config_item(MODE_ADD, 32'd3, 32'd1, 2'd0, 16'h5555, 1'b1, 1'b0));
      for (int k = 4; k < 8; k++) begin
         send_item(config_item(MODE_ADD, k, $urandom_range(0, 8), 2'($urandom_range(0, 3)),
                               16'($urandom), 1'b1, 1'b1));
      end
      send_item(tick_item(32'd5, 1'b0));
      send_item(tick_item(32'hFFFF_FFFF, 1'b1));
      send_item(config_item(MODE_UPDATE, 32'hFFFF_FFFF, 32'd0, 2'd2, 16'h8000, 1'b1, 1'b1));
      send_item(make_item(MODE_ERROR, 32'd1));
      send_item(make_item(MODE_SUCCESS, 32'd1));
      send_item(make_item(MODE_REMOVE, 32'd0));
      send_item(make_item(MODE_SPARE_A, 32'd1));
      send_item(make_item(MODE_SPARE_B, 32'd1));
      send_item(tick_item(32'd3, 1'b0));

      // Random part over a small id pool, so that most items hit live channels.
      burst_at = $urandom_range(80, 160);
      tick_now = 32'hFFFF_FF00;
      round = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (round % 40 == 0) steady <= ($urandom_range(0, 99) < 25);
         if (round == burst_at) begin
            // Clear the pool's channels, then drive one channel to the error cap.
            burst_id = id_pool[$urandom_range(2, POOL_SIZE - 1)];
            foreach (id_pool[i]) send_item(make_item(MODE_REMOVE, id_pool[i]));
            send_item(config_item(MODE_ADD, burst_id, 32'd1, 2'd1, 16'($urandom), 1'b1, 1'b1));
            repeat (ERROR_BURST) send_item(make_item(MODE_ERROR, burst_id));
         end
         pick = $urandom_range(0, 99);
         it = make_item(MODE_TICK, id_pool[$urandom_range(0, POOL_SIZE - 1)]);
         if (pick < 35) begin
            if ($urandom_range(0, 99) < 85) tick_now = tick_now + $urandom_range(0, 25);
            else if ($urandom_range(0, 99) < 70) tick_now = tick_now + $urandom_range(100, 5000);
            else tick_now = $urandom;
            it.now_ticks = tick_now;
            it.backpressure = ($urandom_range(0, 99) < 20);
         end else if (pick < 62) begin
            it.mode = (pick < 52) ? MODE_ADD : MODE_UPDATE;
            it.interval_ticks = pick_interval();
            it.has_template = ($urandom_range(0, 99) < 80);
            it.chan_enabled = ($urandom_range(0, 99) < 85);
         end else if (pick < 69) begin
            it.mode = MODE_REMOVE;
         end else if (pick < 86) begin
            it.mode = MODE_ERROR;
         end else if (pick < 95) begin
            it.mode = MODE_SUCCESS;
         end else begin
            it = noise_item();
         end
         send_item(it);
         round++;
      end
      req_ch.valid <= 1'b0;
      steady <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (CHANNELS + 8) @(posedge clock);

      $display("Sent %0d items (%0d ticks); checked %0d results with %0d commands and %0d drops.",
               items_sent, ticks_sent, results_checked, issued_count, drop_count);
      $display("Backoff held back %0d due samples.", backoff_holds);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
